// ===== rtl/tak_pkg.sv =====
// shared types, constants and microcode for the tilt angle kalman filter
package tak_pkg;

  localparam int DATA_W     = 32;
  localparam int OPND_W     = 33;
  localparam int DT_W       = 17;
  localparam int NOISE_W    = 16;
  localparam int MNOISE_W   = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int STEP_W     = 5;

  localparam logic [STEP_W-1:0] LAST_STEP = 5'd27;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 2'd3;

  localparam logic [DT_W-1:0]     STEP_TIME_RST     = 17'd655;
  localparam logic [NOISE_W-1:0]  ANGLE_NOISE_RST   = 16'd66;
  localparam logic [NOISE_W-1:0]  BIAS_NOISE_RST    = 16'd197;
  localparam logic [MNOISE_W-1:0] MEASURE_NOISE_RST = 31'd1966;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_WAIT
  } alu_op_e;

  typedef enum logic [4:0] {
    SRC_ANGLE,
    SRC_BIAS,
    SRC_AA,
    SRC_AB,
    SRC_BA,
    SRC_BB,
    SRC_GYRO,
    SRC_MEAS,
    SRC_DT,
    SRC_ANOISE,
    SRC_BNOISE,
    SRC_MNOISE,
    SRC_TMP,
    SRC_T,
    SRC_Y,
    SRC_M,
    SRC_K0,
    SRC_K1
  } src_e;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_ANGLE,
    DST_BIAS,
    DST_AA,
    DST_AB,
    DST_BA,
    DST_BB,
    DST_TMP,
    DST_T,
    DST_Y,
    DST_M,
    DST_S
  } dst_e;

  typedef struct packed {
    alu_op_e op;
    src_e    src_a;
    src_e    src_b;
    dst_e    dst;
  } uinst_t;

  function automatic uinst_t mk(input alu_op_e op, input src_e a, input src_e b,
                                input dst_e d);
    uinst_t u;
    u.op    = op;
    u.src_a = a;
    u.src_b = b;
    u.dst   = d;
    return u;
  endfunction

  // one saturating operation per step, but for the gain wait step
  function automatic uinst_t ucode(input logic [STEP_W-1:0] step);
    uinst_t u;
    case (step)
      // predict
      5'd0:    u = mk(OP_SUB, SRC_GYRO,   SRC_BIAS,   DST_TMP);
      5'd1:    u = mk(OP_MUL, SRC_TMP,    SRC_DT,     DST_M);
      5'd2:    u = mk(OP_ADD, SRC_ANGLE,  SRC_M,      DST_ANGLE);
      5'd3:    u = mk(OP_MUL, SRC_BB,     SRC_DT,     DST_T);
      5'd4:    u = mk(OP_ADD, SRC_ANOISE, SRC_T,      DST_TMP);
      5'd5:    u = mk(OP_SUB, SRC_TMP,    SRC_BA,     DST_TMP);
      5'd6:    u = mk(OP_SUB, SRC_TMP,    SRC_AB,     DST_TMP);
      5'd7:    u = mk(OP_MUL, SRC_TMP,    SRC_DT,     DST_M);
      5'd8:    u = mk(OP_ADD, SRC_AA,     SRC_M,      DST_AA);
      5'd9:    u = mk(OP_SUB, SRC_AB,     SRC_T,      DST_AB);
      5'd10:   u = mk(OP_SUB, SRC_BA,     SRC_T,      DST_BA);
      5'd11:   u = mk(OP_MUL, SRC_BNOISE, SRC_DT,     DST_M);
      5'd12:   u = mk(OP_ADD, SRC_BB,     SRC_M,      DST_BB);
      // gain
      5'd13:   u = mk(OP_ADD, SRC_AA,     SRC_MNOISE, DST_S);
      5'd14:   u = mk(OP_SUB, SRC_MEAS,   SRC_ANGLE,  DST_Y);
      5'd15:   u = mk(OP_WAIT, SRC_ANGLE, SRC_ANGLE,  DST_NONE);
      // correct
      5'd16:   u = mk(OP_MUL, SRC_K0,     SRC_Y,      DST_M);
      5'd17:   u = mk(OP_ADD, SRC_ANGLE,  SRC_M,      DST_ANGLE);
      5'd18:   u = mk(OP_MUL, SRC_K1,     SRC_Y,      DST_M);
      5'd19:   u = mk(OP_ADD, SRC_BIAS,   SRC_M,      DST_BIAS);
      // covariance: cov_aa and cov_ab are still the old values when read
      5'd20:   u = mk(OP_MUL, SRC_K1,     SRC_AA,     DST_M);
      5'd21:   u = mk(OP_SUB, SRC_BA,     SRC_M,      DST_BA);
      5'd22:   u = mk(OP_MUL, SRC_K1,     SRC_AB,     DST_M);
      5'd23:   u = mk(OP_SUB, SRC_BB,     SRC_M,      DST_BB);
      5'd24:   u = mk(OP_MUL, SRC_K0,     SRC_AA,     DST_M);
      5'd25:   u = mk(OP_SUB, SRC_AA,     SRC_M,      DST_AA);
      5'd26:   u = mk(OP_MUL, SRC_K0,     SRC_AB,     DST_M);
      5'd27:   u = mk(OP_SUB, SRC_AB,     SRC_M,      DST_AB);
      default: u = mk(OP_WAIT, SRC_ANGLE, SRC_ANGLE,  DST_NONE);
    endcase
    return u;
  endfunction

  function automatic logic signed [OPND_W-1:0] sx(input logic signed [DATA_W-1:0] x);
    return {x[DATA_W-1], x};
  endfunction

endpackage

// ===== rtl/tak_if.sv =====
// valid/ready channels for samples and estimates
interface tak_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       gyro_rate;
  logic signed [31:0]       measured_angle;

  modport source (output valid, gyro_rate, measured_angle, input ready);
  modport sink   (input valid, gyro_rate, measured_angle, output ready);
endinterface

interface tak_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       angle_estimate;
  logic signed [31:0]       bias_estimate;

  modport source (output valid, angle_estimate, bias_estimate, input ready);
  modport sink   (input valid, angle_estimate, bias_estimate, output ready);
endinterface

// ===== rtl/tak_alu.sv =====
// shared saturating q16.16 add, subtract and multiply unit
module tak_alu (
  input  tak_pkg::alu_op_e                  op_i,
  input  logic signed [tak_pkg::OPND_W-1:0] a_i,
  input  logic signed [tak_pkg::OPND_W-1:0] b_i,
  output logic signed [tak_pkg::DATA_W-1:0] y_o
);

  logic signed [2*tak_pkg::OPND_W-1:0] prod;
  logic signed [2*tak_pkg::OPND_W-1:0] wide;

  always_comb begin
    prod = a_i * b_i;
    case (op_i)
      tak_pkg::OP_ADD: wide = a_i + b_i;
      tak_pkg::OP_SUB: wide = a_i - b_i;
      // arithmetic shift floors toward minus infinity
      tak_pkg::OP_MUL: wide = prod >>> 16;
      default:         wide = '0;
    endcase
    if (!wide[2*tak_pkg::OPND_W-1] && (|wide[2*tak_pkg::OPND_W-2:tak_pkg::DATA_W-1])) begin
      y_o = tak_pkg::Q_MAX;
    end else if (wide[2*tak_pkg::OPND_W-1] &&
                 !(&wide[2*tak_pkg::OPND_W-2:tak_pkg::DATA_W-1])) begin
      y_o = tak_pkg::Q_MIN;
    end else begin
      y_o = wide[tak_pkg::DATA_W-1:0];
    end
  end

endmodule

// ===== rtl/tak_div.sv =====
// two-lane serial divider for the gains, shared denominator, one quotient bit a cycle
module tak_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [tak_pkg::DATA_W-1:0] num_a_i,
  input  logic signed [tak_pkg::DATA_W-1:0] num_b_i,
  input  logic signed [tak_pkg::DATA_W-1:0] den_i,
  output logic                              busy_o,
  output logic signed [tak_pkg::DATA_W-1:0] quo_a_o,
  output logic signed [tak_pkg::DATA_W-1:0] quo_b_o
);

  localparam int W = tak_pkg::DATA_W;
  localparam logic [5:0] DIV_STEPS = 6'd32;

  logic              busy_q;
  logic [5:0]        cnt_q;
  logic [W-1:0]      mag_d_q;
  logic              zero_q;
  logic [W-1:0]      rem_q [2];
  logic [W-1:0]      sh_q  [2];
  logic              neg_q [2];
  logic              ovf_q [2];
  logic signed [W-1:0] quo_q [2];

  logic [W-1:0]      rem_d [2];
  logic [W-1:0]      sh_d  [2];
  logic signed [W-1:0] fin [2];
  logic [W-1:0]      mag_n [2];
  logic signed [W-1:0] num [2];
  logic [W-1:0]      mag_d;
  logic [W:0]        trial;
  logic              ge;

  assign busy_o  = busy_q;
  assign quo_a_o = quo_q[0];
  assign quo_b_o = quo_q[1];
  assign num[0]  = num_a_i;
  assign num[1]  = num_b_i;
  assign mag_d   = den_i[W-1] ? W'(-den_i) : W'(den_i);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag_n[l] = num[l][W-1] ? W'(-num[l]) : W'(num[l]);
      trial    = {rem_q[l], sh_q[l][W-1]};
      ge       = (trial >= {1'b0, mag_d_q});
      rem_d[l] = ge ? W'(trial - {1'b0, mag_d_q}) : trial[W-1:0];
      sh_d[l]  = {sh_q[l][W-2:0], ge};
      // truncated magnitude back to a saturated signed value
      if (zero_q) begin
        fin[l] = '0;
      end else if (ovf_q[l]) begin
        fin[l] = neg_q[l] ? tak_pkg::Q_MIN : tak_pkg::Q_MAX;
      end else if (!neg_q[l]) begin
        fin[l] = sh_q[l][W-1] ? tak_pkg::Q_MAX : sh_q[l];
      end else begin
        fin[l] = (sh_q[l] > 32'h8000_0000) ? tak_pkg::Q_MIN : -sh_q[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == DIV_STEPS) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_d_q <= mag_d;
      zero_q  <= (den_i == '0);
      for (int l = 0; l < 2; l++) begin
        neg_q[l] <= num[l][W-1] ^ den_i[W-1];
        ovf_q[l] <= ({16'b0, mag_n[l]} >= {mag_d, 16'b0});
        rem_q[l] <= {16'b0, mag_n[l][W-1:16]};
        sh_q[l]  <= {mag_n[l][15:0], 16'b0};
      end
    end else if (busy_q) begin
      for (int l = 0; l < 2; l++) begin
        if (cnt_q == DIV_STEPS) begin
          quo_q[l] <= fin[l];
        end else begin
          rem_q[l] <= rem_d[l];
          sh_q[l]  <= sh_d[l];
        end
      end
    end
  end

endmodule

// ===== rtl/tilt_angle_kalman_filter_core.sv =====
// top level of the two-state tilt angle kalman filter (angle, gyro bias)
//
//  channel   dir  handshake          payload
//  in_i      in   valid / ready      gyro_rate, measured_angle (q16.16)
//  out_o     out  valid / ready      angle_estimate, bias_estimate (q16.16)
//  cfg       in   cfg_we_i           cfg_idx_i, cfg_wdata_i (write only)
//
// a request runs 27 steps on the shared unit and the gain wait step, which holds while the
// serial divider runs; the sequencer then goes back to idle
// in_i.ready is high only between requests; the result sits in an output
// register, so a new request is taken while the last estimate still waits
// when out_o is stalled at the end of a request, the sequencer holds its last step
// reset clears the estimates, the covariance and loads the default settings
module tilt_angle_kalman_filter_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  tak_in_if.sink                               in_i,
  tak_out_if.source                            out_o,
  input  logic                                 cfg_we_i,
  input  logic [tak_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [tak_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // sequencer
  logic                         state_q, state_d;
  logic [tak_pkg::STEP_W-1:0]   step_q, step_d;
  tak_pkg::uinst_t              uop;
  logic                         adv;
  logic                         wr;
  logic                         last;
  logic                         out_free;
  logic                         in_acc;

  // settings
  logic [tak_pkg::DT_W-1:0]     dt_q;
  logic [tak_pkg::NOISE_W-1:0]  anoise_q;
  logic [tak_pkg::NOISE_W-1:0]  bnoise_q;
  logic [tak_pkg::MNOISE_W-1:0] mnoise_q;

  // filter state
  logic signed [tak_pkg::DATA_W-1:0] angle_q, bias_q, aa_q, ab_q, ba_q, bb_q;

  // per-request scratch
  logic signed [tak_pkg::DATA_W-1:0] gyro_q, meas_q, tmp_q, t_q, y_q, m_q;

  // result register
  logic                              out_valid_q;
  logic signed [tak_pkg::DATA_W-1:0] out_angle_q, out_bias_q;

  // shared units
  logic signed [tak_pkg::OPND_W-1:0] opnd [2];
  tak_pkg::src_e                     sel  [2];
  logic signed [tak_pkg::DATA_W-1:0] alu_y;
  logic                              div_busy;
  logic                              div_start;
  logic signed [tak_pkg::DATA_W-1:0] k0, k1;

  assign uop      = tak_pkg::ucode(step_q);
  assign last     = (step_q == tak_pkg::LAST_STEP);
  assign out_free = !out_valid_q || out_o.ready;
  // the gain wait step holds until both quotients are in; the last step
  // holds until the result register is free
  assign adv      = (state_q == ST_RUN) &&
                    ((uop.op != tak_pkg::OP_WAIT) || !div_busy) &&
                    (!last || out_free);
  assign wr        = adv;
  assign div_start = wr && (uop.dst == tak_pkg::DST_S);
  assign in_acc    = in_i.valid && in_i.ready;

  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.angle_estimate = out_angle_q;
  assign out_o.bias_estimate  = out_bias_q;

  // operand select for both ports of the shared unit
  assign sel[0] = uop.src_a;
  assign sel[1] = uop.src_b;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      case (sel[p])
        tak_pkg::SRC_ANGLE:  opnd[p] = tak_pkg::sx(angle_q);
        tak_pkg::SRC_BIAS:   opnd[p] = tak_pkg::sx(bias_q);
        tak_pkg::SRC_AA:     opnd[p] = tak_pkg::sx(aa_q);
        tak_pkg::SRC_AB:     opnd[p] = tak_pkg::sx(ab_q);
        tak_pkg::SRC_BA:     opnd[p] = tak_pkg::sx(ba_q);
        tak_pkg::SRC_BB:     opnd[p] = tak_pkg::sx(bb_q);
        tak_pkg::SRC_GYRO:   opnd[p] = tak_pkg::sx(gyro_q);
        tak_pkg::SRC_MEAS:   opnd[p] = tak_pkg::sx(meas_q);
        tak_pkg::SRC_DT:     opnd[p] = {16'b0, dt_q};
        tak_pkg::SRC_ANOISE: opnd[p] = {17'b0, anoise_q};
        tak_pkg::SRC_BNOISE: opnd[p] = {17'b0, bnoise_q};
        tak_pkg::SRC_MNOISE: opnd[p] = {2'b0, mnoise_q};
        tak_pkg::SRC_TMP:    opnd[p] = tak_pkg::sx(tmp_q);
        tak_pkg::SRC_T:      opnd[p] = tak_pkg::sx(t_q);
        tak_pkg::SRC_Y:      opnd[p] = tak_pkg::sx(y_q);
        tak_pkg::SRC_M:      opnd[p] = tak_pkg::sx(m_q);
        tak_pkg::SRC_K0:     opnd[p] = tak_pkg::sx(k0);
        tak_pkg::SRC_K1:     opnd[p] = tak_pkg::sx(k1);
        default:             opnd[p] = '0;
      endcase
    end
  end

  tak_alu u_alu (
    .op_i (uop.op),
    .a_i  (opnd[0]),
    .b_i  (opnd[1]),
    .y_o  (alu_y)
  );

  // gains k0 = cov_aa / s and k1 = cov_ba / s, s taken straight off the alu
  tak_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_a_i (aa_q),
    .num_b_i (ba_q),
    .den_i   (alu_y),
    .busy_o  (div_busy),
    .quo_a_o (k0),
    .quo_b_o (k1)
  );

  // next state of the sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        if (adv) begin
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            step_d = step_q + 5'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (adv && last) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // settings, masked to their widths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q     <= tak_pkg::STEP_TIME_RST;
      anoise_q <= tak_pkg::ANGLE_NOISE_RST;
      bnoise_q <= tak_pkg::BIAS_NOISE_RST;
      mnoise_q <= tak_pkg::MEASURE_NOISE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tak_pkg::CFG_STEP_TIME:     dt_q     <= cfg_wdata_i[tak_pkg::DT_W-1:0];
        tak_pkg::CFG_ANGLE_NOISE:   anoise_q <= cfg_wdata_i[tak_pkg::NOISE_W-1:0];
        tak_pkg::CFG_BIAS_NOISE:    bnoise_q <= cfg_wdata_i[tak_pkg::NOISE_W-1:0];
        tak_pkg::CFG_MEASURE_NOISE: mnoise_q <= cfg_wdata_i[tak_pkg::MNOISE_W-1:0];
        default: ;
      endcase
    end
  end

  // filter state write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      bias_q  <= '0;
      aa_q    <= '0;
      ab_q    <= '0;
      ba_q    <= '0;
      bb_q    <= '0;
    end else if (wr) begin
      case (uop.dst)
        tak_pkg::DST_ANGLE: angle_q <= alu_y;
        tak_pkg::DST_BIAS:  bias_q  <= alu_y;
        tak_pkg::DST_AA:    aa_q    <= alu_y;
        tak_pkg::DST_AB:    ab_q    <= alu_y;
        tak_pkg::DST_BA:    ba_q    <= alu_y;
        tak_pkg::DST_BB:    bb_q    <= alu_y;
        default: ;
      endcase
    end
  end

  // scratch, sample capture and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      gyro_q <= in_i.gyro_rate;
      meas_q <= in_i.measured_angle;
    end
    if (wr) begin
      case (uop.dst)
        tak_pkg::DST_TMP: tmp_q <= alu_y;
        tak_pkg::DST_T:   t_q   <= alu_y;
        tak_pkg::DST_Y:   y_q   <= alu_y;
        tak_pkg::DST_M:   m_q   <= alu_y;
        default: ;
      endcase
    end
    // angle and bias are final before the last covariance step
    if (adv && last) begin
      out_angle_q <= angle_q;
      out_bias_q  <= bias_q;
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// self-checking bench for the tilt angle kalman filter core, directed and random samples against a predictor

typedef struct packed {
  logic signed [31:0] angle;
  logic signed [31:0] bias;
} filter_estimate_t;

class kalman_tracker;
  logic [tak_pkg::DT_W-1:0]     step_time;
  logic [tak_pkg::NOISE_W-1:0]  angle_noise;
  logic [tak_pkg::NOISE_W-1:0]  bias_noise;
  logic [tak_pkg::MNOISE_W-1:0] measure_noise;

  logic signed [31:0] angle, bias, p_aa, p_ab, p_ba, p_bb;
  filter_estimate_t   expected_estimates[$];
  int mismatches, samples_seen, zero_gain_steps, saturated_angles;

  function new();
    step_time     = tak_pkg::STEP_TIME_RST;
    angle_noise   = tak_pkg::ANGLE_NOISE_RST;
    bias_noise    = tak_pkg::BIAS_NOISE_RST;
    measure_noise = tak_pkg::MEASURE_NOISE_RST;
    angle = 0; bias = 0; p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
  endfunction

  static function logic signed [31:0] clip(longint v);
    if (v > longint'(tak_pkg::Q_MAX)) return tak_pkg::Q_MAX;
    if (v < longint'(tak_pkg::Q_MIN)) return tak_pkg::Q_MIN;
    return v[31:0];
  endfunction

  static function logic signed [31:0] sat_add(longint a, longint b);
    return clip(a + b);
  endfunction

  static function logic signed [31:0] sat_sub(longint a, longint b);
    return clip(a - b);
  endfunction

  // floor of the q16.16 product
  static function logic signed [31:0] sat_mul(longint a, longint b);
    longint p;
    p = a * b;
    return clip(p >>> 16);
  endfunction

  static function logic signed [31:0] sat_div(longint num, longint den);
    if (den == 0) return 0;
    return clip((num * 65536) / den);
  endfunction

  function void write_reg(logic [tak_pkg::CFG_IDX_W-1:0] idx,
                          logic [tak_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      tak_pkg::CFG_STEP_TIME:     step_time     = data[tak_pkg::DT_W-1:0];
      tak_pkg::CFG_ANGLE_NOISE:   angle_noise   = data[tak_pkg::NOISE_W-1:0];
      tak_pkg::CFG_BIAS_NOISE:    bias_noise    = data[tak_pkg::NOISE_W-1:0];
      tak_pkg::CFG_MEASURE_NOISE: measure_noise = data[tak_pkg::MNOISE_W-1:0];
      default: ;
    endcase
  endfunction

  // one predict / gain / correct pass, covariance corrected from pre-update terms
  function void note_sample(logic signed [31:0] gyro, logic signed [31:0] meas);
    longint dt;
    logic signed [31:0] rate, t, a, s, k0, k1, y, pa, pb;
    dt   = longint'(step_time);
    rate = sat_sub(gyro, bias);
    angle = sat_add(angle, sat_mul(rate, dt));
    t = sat_mul(p_bb, dt);
    a = sat_add(angle_noise, t);
    a = sat_sub(a, p_ba);
    a = sat_sub(a, p_ab);
    p_aa = sat_add(p_aa, sat_mul(a, dt));
    p_ab = sat_sub(p_ab, t);
    p_ba = sat_sub(p_ba, t);
    p_bb = sat_add(p_bb, sat_mul(bias_noise, dt));
    s = sat_add(p_aa, measure_noise);
    if (s == 0) zero_gain_steps++;
    k0 = sat_div(p_aa, s);
    k1 = sat_div(p_ba, s);
    y = sat_sub(meas, angle);
    angle = sat_add(angle, sat_mul(k0, y));
    bias  = sat_add(bias, sat_mul(k1, y));
    pa = p_aa;
    pb = p_ab;
    p_aa = sat_sub(p_aa, sat_mul(k0, pa));
    p_ab = sat_sub(p_ab, sat_mul(k0, pb));
    p_ba = sat_sub(p_ba, sat_mul(k1, pa));
    p_bb = sat_sub(p_bb, sat_mul(k1, pb));
    if (angle == tak_pkg::Q_MAX || angle == tak_pkg::Q_MIN) saturated_angles++;
    samples_seen++;
    expected_estimates.push_back('{angle: angle, bias: bias});
  endfunction

  function void check_estimate(logic signed [31:0] got_angle, logic signed [31:0] got_bias);
    filter_estimate_t want;
    if (expected_estimates.size() == 0) begin
      $error("estimate with no sample pending: angle %0d bias %0d", got_angle, got_bias);
      mismatches++;
      return;
    end
    want = expected_estimates.pop_front();
    if (got_angle !== want.angle) begin
      $error("angle_estimate: expected %0d, got %0d", want.angle, got_angle);
      mismatches++;
    end
    if (got_bias !== want.bias) begin
      $error("bias_estimate: expected %0d, got %0d", want.bias, got_bias);
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_estimates.size();
  endfunction
endclass

module testbench;
  logic clk_i;
  logic rst_ni;
  logic                            cfg_we_i;
  logic [tak_pkg::CFG_IDX_W-1:0]   cfg_idx_i;
  logic [tak_pkg::CFG_DATA_W-1:0]  cfg_wdata_i;

  tak_in_if  samples_if ();
  tak_out_if estimates_if ();

  tilt_angle_kalman_filter_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (samples_if),
    .out_o       (estimates_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  kalman_tracker tracker = new();

  // no idle bursts on either side once set (tail of the run)
  bit calm;
  // long output stalls asked for by the stimulus, served by the receiver
  int hold_requests, holds_served;
  int settings_applied;

  // simulated motion for well-formed sample streams
  int motion_angle, motion_rate, motion_bias;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit, far above the slowest legal run
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiver: random ready bursts, one long stall per hold request
  initial begin
    int stall_left;
    stall_left = 0;
    estimates_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && estimates_if.valid && estimates_if.ready)
        tracker.check_estimate(estimates_if.angle_estimate, estimates_if.bias_estimate);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        // long enough for a request in flight plus one more to back up the input
        stall_left = 500;
        estimates_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        estimates_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        estimates_if.ready <= 1'b0;
      end else begin
        estimates_if.ready <= 1'b1;
      end
    end
  end

  // offer one request and wait for it to be taken, sometimes after a short gap
  task automatic send_request(logic signed [31:0] gyro, logic signed [31:0] meas);
    if (!calm && $urandom_range(0, 3) == 0) begin
      samples_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    samples_if.valid          <= 1'b1;
    samples_if.gyro_rate      <= gyro;
    samples_if.measured_angle <= meas;
    do @(posedge clk_i); while (!samples_if.ready);
    tracker.note_sample(gyro, meas);
  endtask

  // stop offering and wait until every estimate is back
  task automatic drain_filter();
    samples_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_setting(logic [tak_pkg::CFG_IDX_W-1:0] idx,
                               logic [tak_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // settings only change with the filter empty
  task automatic apply_settings(logic [30:0] st, logic [30:0] an, logic [30:0] bn,
                                logic [30:0] mn);
    drain_filter();
    // short pause so the sequencer is back at rest
    repeat (4) @(posedge clk_i);
    write_setting(tak_pkg::CFG_STEP_TIME, st);
    write_setting(tak_pkg::CFG_ANGLE_NOISE, an);
    write_setting(tak_pkg::CFG_BIAS_NOISE, bn);
    write_setting(tak_pkg::CFG_MEASURE_NOISE, mn);
    settings_applied++;
  endtask

  function automatic logic signed [31:0] corner_value();
    case ($urandom_range(0, 4))
      0:       return tak_pkg::Q_MIN;
      1:       return tak_pkg::Q_MAX;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  // mostly plausible motion, with full-range noise, corners and tiny values mixed in
  task automatic next_sample(output logic signed [31:0] gyro, output logic signed [31:0] meas);
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      motion_rate += int'($urandom_range(0, 131072)) - 65536;
      if (motion_rate > 300 * 65536) motion_rate = 300 * 65536;
      if (motion_rate < -300 * 65536) motion_rate = -300 * 65536;
      motion_angle += motion_rate / 100;
      if (motion_angle > 180 * 65536) motion_angle = 180 * 65536;
      if (motion_angle < -180 * 65536) motion_angle = -180 * 65536;
      if ($urandom_range(0, 49) == 0)
        motion_bias = int'($urandom_range(0, 20 * 65536)) - 10 * 65536;
      gyro = motion_rate + motion_bias + int'($urandom_range(0, 65536)) - 32768;
      meas = motion_angle + int'($urandom_range(0, 262144)) - 131072;
    end else if (kind < 85) begin
      gyro = $urandom;
      meas = $urandom;
    end else if (kind < 95) begin
      gyro = corner_value();
      meas = corner_value();
    end else begin
      gyro = int'($urandom_range(0, 2000)) - 1000;
      meas = int'($urandom_range(0, 2000)) - 1000;
    end
  endtask

  initial begin
    logic signed [31:0] gyro, meas;
    logic [30:0] st, an, bn, mn;

    rst_ni                    <= 1'b0;
    samples_if.valid          <= 1'b0;
    samples_if.gyro_rate      <= '0;
    samples_if.measured_angle <= '0;
    cfg_we_i                  <= 1'b0;
    cfg_idx_i                 <= tak_pkg::CFG_STEP_TIME;
    cfg_wdata_i               <= '0;
    calm = 1'b0;
    hold_requests = 0;
    settings_applied = 0;
    motion_angle = 0;
    motion_rate = 0;
    motion_bias = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero noises on a fresh covariance keep the gain denominator at zero
    apply_settings(31'd65536, 31'd0, 31'd0, 31'd0);
    send_request(tak_pkg::Q_MAX, tak_pkg::Q_MAX);
    send_request(tak_pkg::Q_MIN, tak_pkg::Q_MIN);
    send_request(0, 0);
    send_request(-1, 1);
    send_request(1, -1);
    send_request(tak_pkg::Q_MAX, tak_pkg::Q_MIN);
    send_request(tak_pkg::Q_MIN, tak_pkg::Q_MAX);

    // back to the power-up settings, normal gain path
    apply_settings(31'(tak_pkg::STEP_TIME_RST), 31'(tak_pkg::ANGLE_NOISE_RST),
                   31'(tak_pkg::BIAS_NOISE_RST), 31'(tak_pkg::MEASURE_NOISE_RST));
    send_request(65536, 30 * 65536);
    send_request(-65536, 29 * 65536);
    send_request(tak_pkg::Q_MAX, 0);
    send_request(tak_pkg::Q_MIN, 0);
    send_request(0, tak_pkg::Q_MAX);
    send_request(0, tak_pkg::Q_MIN);

    // oversize step time is cut to the register width, noises at their ceiling
    apply_settings(31'h7fff_ffff, 31'd65535, 31'd65535, 31'h7fff_ffff);
    send_request(tak_pkg::Q_MAX, tak_pkg::Q_MAX);
    send_request(tak_pkg::Q_MIN, tak_pkg::Q_MIN);
    send_request(-1, -1);
    send_request(12345, -54321);
    send_request(tak_pkg::Q_MIN, tak_pkg::Q_MAX);
    send_request(0, 0);

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin
          st = 31'(tak_pkg::STEP_TIME_RST); an = 31'(tak_pkg::ANGLE_NOISE_RST);
          bn = 31'(tak_pkg::BIAS_NOISE_RST); mn = 31'(tak_pkg::MEASURE_NOISE_RST);
        end
        1: begin
          st = 31'd1; an = 31'd0; bn = 31'd65535; mn = 31'd1;
        end
        2: begin
          st = 31'd65536; an = 31'($urandom_range(0, 65535));
          bn = 31'($urandom_range(0, 65535));
          mn = 31'h7fff_ffff;
        end
        3: begin
          // step time of zero freezes the prediction, no measurement noise
          st = 31'd0; an = 31'($urandom_range(0, 65535));
          bn = 31'($urandom_range(0, 65535));
          mn = 31'd0;
        end
        8: begin
          st = 31'(tak_pkg::STEP_TIME_RST); an = 31'(tak_pkg::ANGLE_NOISE_RST);
          bn = 31'(tak_pkg::BIAS_NOISE_RST); mn = 31'(tak_pkg::MEASURE_NOISE_RST);
        end
        default: begin
          st = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 131071)) :
                                             31'($urandom_range(1, 3000));
          an = 31'($urandom_range(0, 65535));
          bn = 31'($urandom_range(0, 65535));
          mn = ($urandom_range(0, 1) == 0) ? 31'($urandom) : 31'($urandom_range(1, 100000));
        end
      endcase
      apply_settings(st, an, bn, mn);
      // tail of the run goes without idle gaps
      if (phase == 8) calm = 1'b1;
      for (int n = 0; n < 170; n++) begin
        // output held off for a long stretch while requests keep coming
        if (phase == 2 && n == 30) hold_requests++;
        // sender pauses until the filter has emptied
        if (phase == 4 && n == 60) drain_filter();
        next_sample(gyro, meas);
        send_request(gyro, meas);
      end
    end

    drain_filter();
    repeat (100) @(posedge clk_i);
    $display("run: %0d samples over %0d filter settings, %0d with zero gain denominator",
             tracker.samples_seen, settings_applied, tracker.zero_gain_steps);
    $display("run: %0d saturated angle estimates, %0d long output stalls",
             tracker.saturated_angles, holds_served);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/tak_pkg.sv
rtl/tak_if.sv
rtl/tak_alu.sv
rtl/tak_div.sv
rtl/tilt_angle_kalman_filter_core.sv
bench/testbench.sv
